>>> rtl/glcd_text_character_writer_macros.svh
// Assertion macros for the text character writer bus sequencer module
`ifndef GLCD_TEXT_CHARACTER_WRITER_MACROS_SVH
`define GLCD_TEXT_CHARACTER_WRITER_MACROS_SVH

`ifndef SYNTHESIS
`define GLCD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("glcd assertion failed");
`define GLCD_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("glcd forbidden condition seen");
`else
`define GLCD_ASSERT(lbl, clk, rst_n, prop)
`define GLCD_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

>>> rtl/glcd_pkg.sv
// Types, constants and font ROM for the graphic LCD text character writer
package glcd_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_DATA_W  = 5;

    localparam logic [4:0] CELLS_PER_HALF = 5'd10;
    localparam logic [4:0] LAST_COL       = 5'd19;
    localparam logic [7:0] PAGE_CMD_BASE  = 8'hB8;
    localparam logic [7:0] COL_CMD_BASE   = 8'h40;
    localparam logic [7:0] LEFT_OFFSET    = 8'h04;
    localparam logic [7:0] CURSOR_BIT     = 8'h80;
    localparam logic [7:0] BLANK_BYTE     = 8'h00;
    localparam logic [6:0] FIRST_CODE     = 7'h20;
    localparam logic [6:0] DEL_CODE       = 7'h7F;

    localparam logic [2:0] STEP_PAGE   = 3'd0;
    localparam logic [2:0] STEP_COLUMN = 3'd1;
    localparam logic [2:0] STEP_GLYPH  = 3'd2;
    localparam logic [2:0] STEP_BLANK  = 3'd7;

    typedef enum logic [1:0] {
        CS_LEFT  = 2'd1,
        CS_RIGHT = 2'd2,
        CS_BOTH  = 2'd3
    } t_cs;

    typedef enum logic {
        WK_INSTR = 1'b0,
        WK_DATA  = 1'b1
    } t_write_kind;

    typedef enum logic {
        CMD_SET_POS    = 1'b0,
        CMD_WRITE_CHAR = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        CFG_CURSOR_ENABLE = 2'd0,
        CFG_CURSOR_ROW    = 2'd1,
        CFG_CURSOR_COL    = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic       command;
        logic [2:0] row;
        logic [4:0] col;
        logic [6:0] char_code;
    } t_in_item;

    typedef struct packed {
        logic       write_kind;
        logic [1:0] chip_select;
        logic [7:0] bus_byte;
        logic       last_write;
    } t_out_item;

    typedef struct packed {
        logic       is_char;
        logic [2:0] row;
        logic [1:0] cs;
        logic [7:0] col_byte;
        logic [6:0] char_code;
        logic       mark;
    } t_job;

    localparam logic [39:0] FONT_ROM [0:94] = '{
        40'h0000000000, 40'h00004f0000, 40'h0007000700, 40'h147f147f14, 40'h242a7f2a12,
        40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001c224100, 40'h0041221c00,
        40'h14083e0814, 40'h08083e0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
        40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503, 40'h3649494936,
        40'h064949291e, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
        40'h0041221408, 40'h0201510906, 40'h324979413e, 40'h7e1111117e, 40'h7f49494936,
        40'h3e41414122, 40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
        40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
        40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e, 40'h7f09090906, 40'h3e4151215e,
        40'h7f09192946, 40'h2649494932, 40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f,
        40'h3f4038403f, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
        40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
        40'h2054545478, 40'h7f48444438, 40'h3844444420, 40'h384444487f, 40'h3854545418,
        40'h087e090102, 40'h0c5252523e, 40'h7f08040478, 40'h00047d0000, 40'h2040443d00,
        40'h7f10284400, 40'h00417f4000, 40'h7c0418047c, 40'h7c08040478, 40'h3844444438,
        40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420, 40'h043f444020,
        40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c, 40'h4428102844, 40'h0c5050503c,
        40'h4464544c44, 40'h0008364100, 40'h0000770000, 40'h0041360800, 40'h0804081008
    };

    function automatic logic [7:0] font_byte(input logic [6:0] code, input logic [2:0] idx);
        logic [6:0]  ofs;
        logic [39:0] glyph;
        logic [39:0] shifted;
        ofs     = code - FIRST_CODE;
        glyph   = ((code >= FIRST_CODE) && (code != DEL_CODE)) ? FONT_ROM[ofs] : 40'd0;
        shifted = glyph << {idx, 3'b000};
        return shifted[39:32];
    endfunction

endpackage

>>> rtl/glcd_front.sv
// Front end: takes items, tracks text position and cursor, builds bus jobs
module glcd_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  glcd_pkg::t_in_item                  i_in_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [1:0]                          i_cfg_index,
    input  logic [glcd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_queue_full,
    output logic                                o_push,
    output glcd_pkg::t_job                      o_job
);

    logic       r_cursor_en;
    logic [2:0] r_cursor_row;
    logic [4:0] r_cursor_col;
    logic [2:0] r_row;
    logic [4:0] r_col;
    logic [2:0] n_row;
    logic [4:0] n_col;
    logic [2:0] pos_row;
    logic [4:0] pos_col;
    logic [7:0] cell_x;
    logic       is_char;
    logic       left;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_queue_full;
    assign o_push      = i_in_valid && !i_queue_full;
    assign is_char     = (i_in_item.command == glcd_pkg::CMD_WRITE_CHAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_en  <= 1'b0;
            r_cursor_row <= '0;
            r_cursor_col <= '0;
        end else if (i_cfg_valid) begin
            unique case (glcd_pkg::t_cfg_index'(i_cfg_index))
                glcd_pkg::CFG_CURSOR_ENABLE: r_cursor_en  <= i_cfg_data[0];
                glcd_pkg::CFG_CURSOR_ROW:    r_cursor_row <= i_cfg_data[2:0];
                glcd_pkg::CFG_CURSOR_COL:    r_cursor_col <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (is_char) begin
            pos_row = r_row;
            pos_col = r_col;
        end else begin
            pos_row = i_in_item.row;
            pos_col = (i_in_item.col > glcd_pkg::LAST_COL) ? glcd_pkg::LAST_COL
                                                            : i_in_item.col;
        end
        left   = (pos_col < glcd_pkg::CELLS_PER_HALF);
        cell_x = left ? {3'b000, pos_col} : {3'b000, pos_col - glcd_pkg::CELLS_PER_HALF};

        o_job.is_char   = is_char;
        o_job.row       = pos_row;
        o_job.cs        = left ? glcd_pkg::CS_LEFT : glcd_pkg::CS_RIGHT;
        o_job.col_byte  = glcd_pkg::COL_CMD_BASE + cell_x * 8'd6
                        + (left ? glcd_pkg::LEFT_OFFSET : 8'd0);
        o_job.char_code = i_in_item.char_code;
        o_job.mark      = r_cursor_en && (r_row == r_cursor_row) && (r_col == r_cursor_col);

        if (!is_char) begin
            n_row = pos_row;
            n_col = pos_col;
        end else if (r_col == glcd_pkg::LAST_COL) begin
            n_row = r_row + 3'd1;
            n_col = '0;
        end else begin
            n_row = r_row;
            n_col = r_col + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (o_push) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

>>> rtl/glcd_queue.sv
// Short job queue between the front end and the bus sequencer
module glcd_queue #(
    parameter int DEPTH = glcd_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  glcd_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output glcd_pkg::t_job  o_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    glcd_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/glcd_back.sv
// Bus sequencer: expands each job into LCD bus writes behind an output register
`include "glcd_text_character_writer_macros.svh"

module glcd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    input  glcd_pkg::t_job       i_job,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output glcd_pkg::t_out_item  o_out_item
);

    logic [2:0]          r_step;
    logic [2:0]          n_step;
    logic                r_out_valid;
    glcd_pkg::t_out_item r_out;
    glcd_pkg::t_out_item n_out;
    logic                load;
    logic [2:0]          glyph_idx;
    logic [7:0]          glyph;

    assign load        = i_job_valid && (!r_out_valid || !i_out_stall);
    assign o_pop       = load && n_out.last_write;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign glyph_idx   = r_step - glcd_pkg::STEP_GLYPH;
    assign glyph       = glcd_pkg::font_byte(i_job.char_code, glyph_idx)
                       | (i_job.mark ? glcd_pkg::CURSOR_BIT : 8'h00);

    always_comb begin
        n_out.last_write = 1'b0;
        if (r_step == glcd_pkg::STEP_PAGE) begin
            n_out.write_kind  = glcd_pkg::WK_INSTR;
            n_out.chip_select = glcd_pkg::CS_BOTH;
            n_out.bus_byte    = glcd_pkg::PAGE_CMD_BASE + {5'd0, i_job.row};
        end else if (r_step == glcd_pkg::STEP_COLUMN) begin
            n_out.write_kind  = glcd_pkg::WK_INSTR;
            n_out.chip_select = i_job.cs;
            n_out.bus_byte    = i_job.col_byte;
            n_out.last_write  = !i_job.is_char;
        end else if (r_step == glcd_pkg::STEP_BLANK) begin
            n_out.write_kind  = glcd_pkg::WK_DATA;
            n_out.chip_select = i_job.cs;
            n_out.bus_byte    = glcd_pkg::BLANK_BYTE;
            n_out.last_write  = 1'b1;
        end else begin
            n_out.write_kind  = glcd_pkg::WK_DATA;
            n_out.chip_select = i_job.cs;
            n_out.bus_byte    = glyph;
        end
        n_step = n_out.last_write ? glcd_pkg::STEP_PAGE : r_step + 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= glcd_pkg::STEP_PAGE;
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_step      <= n_step;
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    `GLCD_ASSERT(a_mid_job_has_job, i_clk, i_rst_n, (r_step != glcd_pkg::STEP_PAGE) |-> i_job_valid)
    `GLCD_ASSERT(a_last_restarts, i_clk, i_rst_n, o_pop |=> (r_step == glcd_pkg::STEP_PAGE))
    `GLCD_ASSERT_NEVER(a_setpos_short, i_clk, i_rst_n, i_job_valid && !i_job.is_char && (r_step > glcd_pkg::STEP_COLUMN))

endmodule

>>> rtl/glcd_text_character_writer.sv
// Top level of the graphic LCD text character writer
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_stall   | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_item (t_out_item)
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A set-position item yields 2 bus writes, a write-character item 8; the
// sequencer issues one write per cycle while the output is not stalled.
// Items enter a QUEUE_DEPTH-entry job queue and are taken while the queue has room.
// Reset is synchronous, active low, and clears position, cursor and queue.
// An output stall holds the output register and backs up through the queue.
module glcd_text_character_writer #(
    parameter int QUEUE_DEPTH = glcd_pkg::QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  glcd_pkg::t_in_item               i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output glcd_pkg::t_out_item              o_out_item,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [1:0]                       i_cfg_index,
    input  logic [glcd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic           push;
    logic           pop;
    logic           queue_full;
    logic           job_valid;
    glcd_pkg::t_job front_job;
    glcd_pkg::t_job head_job;

    glcd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_job        (front_job)
    );

    glcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_job   (head_job)
    );

    glcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

>>> dv/glcd_text_character_writer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the graphic LCD text character writer: random and directed items
module glcd_text_character_writer_tb;

    localparam logic [7:0] PAGE_BASE       = 8'hB8;
    localparam logic [7:0] COL_BASE        = 8'h40;
    localparam logic [7:0] MARK_BIT        = 8'h80;
    localparam logic [7:0] BLANK           = 8'h00;
    localparam logic [4:0] HALF_CELLS      = 5'd10;
    localparam logic [4:0] LAST_CELL       = 5'd19;
    localparam logic [1:0] CFG_SPARE_IDX   = 2'd3;
    localparam int         HOLD_OFF_CYCLES = 120;
    localparam int         IDLE_PCT        = 22;
    localparam int         MAX_REPORTS     = 40;

    localparam logic [39:0] GLYPHS [95] = '{
        40'h0000000000, 40'h00004f0000, 40'h0007000700,
        40'h147f147f14, 40'h242a7f2a12, 40'h2313086462,
        40'h3649552250, 40'h0005030000, 40'h001c224100,
        40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3e5149453e, 40'h00427f4000,
        40'h4261514946, 40'h2141454b31, 40'h1814127f10,
        40'h2745454539, 40'h3c4a494930, 40'h0171090503,
        40'h3649494936, 40'h064949291e, 40'h0036360000,
        40'h0056360000, 40'h0814224100, 40'h1414141414,
        40'h0041221408, 40'h0201510906, 40'h324979413e,
        40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
        40'h7f4141221c, 40'h7f49494941, 40'h7f09090901,
        40'h3e4149497a, 40'h7f0808087f, 40'h00417f4100,
        40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
        40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
        40'h7f09090906, 40'h3e4151215e, 40'h7f09192946,
        40'h2649494932, 40'h01017f0101, 40'h3f4040403f,
        40'h1f2040201f, 40'h3f4038403f, 40'h6314081463,
        40'h0708700807, 40'h6151494543, 40'h007f414100,
        40'h0204081020, 40'h0041417f00, 40'h0402010204,
        40'h4040404040, 40'h0001020400, 40'h2054545478,
        40'h7f48444438, 40'h3844444420, 40'h384444487f,
        40'h3854545418, 40'h087e090102, 40'h0c5252523e,
        40'h7f08040478, 40'h00047d0000, 40'h2040443d00,
        40'h7f10284400, 40'h00417f4000, 40'h7c0418047c,
        40'h7c08040478, 40'h3844444438, 40'h7c14141408,
        40'h081414187c, 40'h7c08040408, 40'h4854545420,
        40'h043f444020, 40'h3c4040207c, 40'h1c2040201c,
        40'h3c4030403c, 40'h4428102844, 40'h0c5050503c,
        40'h4464544c44, 40'h0008364100, 40'h0000770000,
        40'h0041360800, 40'h0804081008
    };

    logic                            i_clk;
    logic                            i_rst_n     = 1'b0;
    logic                            i_in_valid  = 1'b0;
    logic                            o_in_stall;
    glcd_pkg::t_in_item              i_in_item   = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    glcd_pkg::t_out_item             o_out_item;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [1:0]                      i_cfg_index = '0;
    logic [glcd_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    glcd_pkg::t_in_item  pending_items [$];
    glcd_pkg::t_out_item bus_writes_due [$];

    logic       cur_en  = 1'b0;
    logic [2:0] cur_row = '0;
    logic [4:0] cur_col = '0;
    logic [2:0] pos_row = '0;
    logic [4:0] pos_col = '0;

    bit in_taken    = 1'b0;
    bit no_idle     = 1'b0;
    int stall_hold  = 0;
    int errors      = 0;
    int items_taken = 0;
    int chars_drawn = 0;
    int marked_cells = 0;
    int writes_seen = 0;
    int settings_run = 0;

    glcd_text_character_writer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #800000;
        $display("Timeout with %0d bus writes still due", bus_writes_due.size());
        $display("FAIL glcd_text_character_writer");
        $finish;
    end

    function automatic glcd_pkg::t_cs half_for(logic [4:0] c);
        return (c < HALF_CELLS) ? glcd_pkg::CS_LEFT : glcd_pkg::CS_RIGHT;
    endfunction

    function automatic void push_write(glcd_pkg::t_write_kind kind, glcd_pkg::t_cs cs,
                                       logic [7:0] data, logic last);
        glcd_pkg::t_out_item w;
        w.write_kind  = kind;
        w.chip_select = cs;
        w.bus_byte    = data;
        w.last_write  = last;
        bus_writes_due.push_back(w);
    endfunction

    function automatic void push_address(logic last);
        logic [7:0] col8;
        logic [7:0] row8;
        logic [7:0] col_byte;
        col8 = {3'b000, pos_col};
        row8 = {5'b00000, pos_row};
        if (pos_col < HALF_CELLS) begin
            col_byte = COL_BASE + col8 * 8'd6 + 8'd4;
        end else begin
            col_byte = COL_BASE + (col8 - 8'd10) * 8'd6;
        end
        push_write(glcd_pkg::WK_INSTR, glcd_pkg::CS_BOTH, PAGE_BASE + row8, 1'b0);
        push_write(glcd_pkg::WK_INSTR, half_for(pos_col), col_byte, last);
    endfunction

    function automatic void predict_bus_writes(glcd_pkg::t_in_item it);
        logic [39:0]   glyph;
        logic [7:0]    b;
        glcd_pkg::t_cs cs;
        logic          mark;
        if (it.command == glcd_pkg::CMD_SET_POS) begin
            pos_row = it.row;
            pos_col = (it.col > LAST_CELL) ? LAST_CELL : it.col;
            push_address(1'b1);
        end else begin
            cs    = half_for(pos_col);
            mark  = cur_en && (pos_row == cur_row) && (pos_col == cur_col);
            glyph = (it.char_code >= 7'h20 && it.char_code != 7'h7F) ?
                    GLYPHS[it.char_code - 7'h20] : '0;
            push_address(1'b0);
            for (int i = 0; i < 5; i++) begin
                b = glyph[39 - 8*i -: 8];
                if (mark) b = b | MARK_BIT;
                push_write(glcd_pkg::WK_DATA, cs, b, 1'b0);
            end
            push_write(glcd_pkg::WK_DATA, cs, BLANK, 1'b1);
            chars_drawn++;
            if (mark) marked_cells++;
            if (pos_col == LAST_CELL) begin
                pos_col = '0;
                pos_row = pos_row + 3'd1;
            end else begin
                pos_col = pos_col + 5'd1;
            end
        end
    endfunction

    function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, what, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            predict_bus_writes(i_in_item);
            items_taken++;
            in_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            in_taken = 1'b0;
            if (pending_items.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                i_in_item  <= pending_items.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_hold > 0) begin
            i_out_stall <= 1'b1;
            stall_hold--;
        end else begin
            i_out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        glcd_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            writes_seen++;
            if (bus_writes_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t ns: bus write with none expected, actual 0x%0h",
                             $time, o_out_item);
            end else begin
                want = bus_writes_due.pop_front();
                check_field("write_kind", {7'd0, want.write_kind},
                            {7'd0, o_out_item.write_kind});
                check_field("chip_select", {6'd0, want.chip_select},
                            {6'd0, o_out_item.chip_select});
                check_field("bus_byte", want.bus_byte, o_out_item.bus_byte);
                check_field("last_write", {7'd0, want.last_write},
                            {7'd0, o_out_item.last_write});
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [4:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            glcd_pkg::CFG_CURSOR_ENABLE: cur_en  = data[0];
            glcd_pkg::CFG_CURSOR_ROW:    cur_row = data[2:0];
            glcd_pkg::CFG_CURSOR_COL:    cur_col = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_cursor(logic [4:0] en, logic [4:0] row, logic [4:0] col);
        write_reg(glcd_pkg::CFG_CURSOR_ENABLE, en);
        write_reg(glcd_pkg::CFG_CURSOR_ROW, row);
        write_reg(glcd_pkg::CFG_CURSOR_COL, col);
        settings_run++;
    endtask

    task automatic queue_item(glcd_pkg::t_command cmd, logic [2:0] row, logic [4:0] col,
                              logic [6:0] code);
        glcd_pkg::t_in_item it;
        it.command   = cmd;
        it.row       = row;
        it.col       = col;
        it.char_code = code;
        pending_items.push_back(it);
    endtask

    task automatic queue_random(int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = int'($urandom_range(99));
            if (r < 70) begin
                queue_item(glcd_pkg::CMD_WRITE_CHAR, 3'($urandom_range(7)),
                           5'($urandom_range(31)),
                           ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                                    : 7'($urandom_range(126, 32)));
            end else if (r < 78 && cur_en) begin
                queue_item(glcd_pkg::CMD_SET_POS, cur_row, cur_col, 7'($urandom_range(127)));
            end else if (r < 85) begin
                queue_item(glcd_pkg::CMD_SET_POS, 3'd7, 5'($urandom_range(19, 15)),
                           7'($urandom_range(127)));
            end else begin
                queue_item(glcd_pkg::CMD_SET_POS, 3'($urandom_range(7)),
                           ($urandom_range(7) == 0) ? 5'($urandom_range(31, 20))
                                                    : 5'($urandom_range(19)),
                           7'($urandom_range(127)));
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || i_in_valid || bus_writes_due.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        logic [4:0] v;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // font extremes, unprintable codes, wrap and saturation at reset settings
        settings_run++;
        queue_item(glcd_pkg::CMD_SET_POS, 3'd0, 5'd0, 7'd0);
        queue_item(glcd_pkg::CMD_WRITE_CHAR, 3'd0, 5'd0, 7'h20);
        queue_item(glcd_pkg::CMD_WRITE_CHAR, 3'd7, 5'd31, 7'h7E);
        queue_item(glcd_pkg::CMD_WRITE_CHAR, 3'd0, 5'd0, 7'h00);
        queue_item(glcd_pkg::CMD_WRITE_CHAR, 3'd0, 5'd0, 7'h7F);
        queue_item(glcd_pkg::CMD_WRITE_CHAR, 3'd0, 5'd0, 7'h1F);
        queue_item(glcd_pkg::CMD_SET_POS, 3'd7, 5'd19, 7'h7F);
        queue_item(glcd_pkg::CMD_WRITE_CHAR, 3'd0, 5'd0, 7'h41);
        queue_item(glcd_pkg::CMD_WRITE_CHAR, 3'd0, 5'd0, 7'h42);
        queue_item(glcd_pkg::CMD_SET_POS, 3'd3, 5'd31, 7'd0);
        queue_item(glcd_pkg::CMD_WRITE_CHAR, 3'd0, 5'd0, 7'h78);
        queue_item(glcd_pkg::CMD_SET_POS, 3'd2, 5'd9, 7'd0);
        queue_item(glcd_pkg::CMD_WRITE_CHAR, 3'd0, 5'd0, 7'h30);
        queue_item(glcd_pkg::CMD_WRITE_CHAR, 3'd0, 5'd0, 7'h39);
        queue_item(glcd_pkg::CMD_SET_POS, 3'd5, 5'd10, 7'd0);
        queue_item(glcd_pkg::CMD_SET_POS, 3'd4, 5'd20, 7'd0);
        wait_drained();

        set_cursor(5'b00001, 5'd0, 5'd0);
        write_reg(CFG_SPARE_IDX, 5'b11111);
        queue_item(glcd_pkg::CMD_SET_POS, 3'd0, 5'd0, 7'd0);
        queue_item(glcd_pkg::CMD_WRITE_CHAR, 3'd0, 5'd0, 7'h23);
        queue_item(glcd_pkg::CMD_WRITE_CHAR, 3'd0, 5'd0, 7'h40);
        queue_random(30);
        wait_drained();

        // receiver holds off while the sender keeps offering
        set_cursor(5'b00001, 5'd7, 5'd19);
        @(posedge i_clk);
        stall_hold = HOLD_OFF_CYCLES;
        queue_item(glcd_pkg::CMD_SET_POS, 3'd7, 5'd19, 7'd0);
        queue_item(glcd_pkg::CMD_WRITE_CHAR, 3'd0, 5'd0, 7'h5A);
        queue_random(32);
        wait_drained();

        v = 5'($urandom_range(31));
        set_cursor(5'b10101, v, 5'd31);
        queue_random(32);
        wait_drained();

        no_idle = 1'b1;
        v = 5'($urandom_range(31));
        set_cursor(5'b11110, v, 5'($urandom_range(19)));
        queue_random(32);
        wait_drained();
        no_idle = 1'b0;

        v = 5'($urandom_range(15));
        set_cursor({v[3:0], 1'b1}, 5'($urandom_range(31)), 5'($urandom_range(19)));
        queue_random(32);
        wait_drained();

        set_cursor(5'($urandom_range(31)), 5'($urandom_range(31)), 5'($urandom_range(31)));
        queue_random(32);
        wait_drained();

        repeat (20) @(posedge i_clk);
        $display("Covered %0d items (%0d characters, %0d on the cursor cell) and %0d bus writes",
                 items_taken, chars_drawn, marked_cells, writes_seen);
        $display("over %0d cursor settings, with a long output hold-off and a no-idle phase",
                 settings_run);
        if (errors == 0) begin
            $display("PASS glcd_text_character_writer");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAIL glcd_text_character_writer");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/glcd_pkg.sv
rtl/glcd_front.sv
rtl/glcd_queue.sv
rtl/glcd_back.sv
rtl/glcd_text_character_writer.sv
dv/glcd_text_character_writer_tb.sv
